### rtl/msp_pkg.sv
// Shared types and codes for the MIDI sustain pedal emulator.
// No dependencies; imported by every module of the block except msp_ram.
package msp_pkg;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CTRL     = 4'hB;
  localparam logic [6:0] SUSTAIN_CC    = 7'd64;
  localparam logic [1:0] MSG_FULL      = 2'd3;
  localparam logic [1:0] MSG_EMPTY     = 2'd0;

  localparam logic [1:0] NOTE_OFF  = 2'd0;
  localparam logic [1:0] NOTE_ON   = 2'd1;
  localparam logic [1:0] NOTE_HELD = 2'd2;

  localparam int IN_W  = 24;
  localparam int OUT_W = 48;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [1:0] msg_length;
  } msg_t;

  typedef struct packed {
    logic [7:0] a_status;
    logic [6:0] a_data1;
    logic [6:0] a_data2;
    logic [1:0] a_length;
    logic [7:0] b_status;
    logic [6:0] b_data1;
    logic [6:0] b_data2;
    logic       last;
  } res_t;

endpackage

### rtl/msp_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module msp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/msp_outreg.sv
// Output register stage for result beats.
// Depends on msp_pkg for the result type.
module msp_outreg
  import msp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  input  res_t res,
  output logic res_ready,
  output logic out_valid,
  output res_t out_res,
  input  logic out_ready
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

### rtl/msp_ctrl.sv
// Sequencer: clear pass, note read-modify-write, pass-through, sustain release scan and flush.
// Depends on msp_pkg; drives the note state RAM and the output register.
module msp_ctrl
  import msp_pkg::*;
#(
  parameter int CHANNELS = 16,
  parameter int NOTES = 128,
  localparam int DEPTH = CHANNELS * NOTES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  msg_t          in_msg,
  output logic          in_ready,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [1:0]    ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [1:0]    ram_rdata,
  output logic          res_valid,
  output res_t          res,
  input  logic          res_ready
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = $clog2(NOTES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_NOTE  = 3'd2;
  localparam logic [2:0] ST_PASS  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] c, logic [NW-1:0] n);
    return AW'(int'(c) * NOTES + int'(n));
  endfunction

  logic [2:0]          state;
  logic [AW-1:0]       clr_cnt;
  logic [CHANNELS-1:0] flags;
  logic [NW:0]         issue_n;
  logic                s1_valid;
  logic [NW-1:0]       s1_note;
  logic                buf_valid;
  logic                buf_full;
  logic [NW-1:0]       buf_a;
  logic [NW-1:0]       buf_b;
  msg_t                msg;

  logic          accept;
  logic [3:0]    in_type;
  logic [3:0]    in_ch;
  logic          in_ch_ok;
  logic          in_is_note;
  logic          in_is_cc;
  logic [3:0]    msg_type;
  logic [3:0]    msg_ch;
  logic [CW-1:0] ch_idx;
  logic          note_on;
  logic          held;
  logic          proc;
  logic          scan_issue;
  logic          scan_end;
  logic          note_done;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_type  = in_msg.status_byte[7:4];
  assign in_ch    = in_msg.status_byte[3:0];
  assign in_ch_ok = ({1'b0, in_ch} < 5'(CHANNELS));
  assign in_is_note = in_msg.status_byte[7] && in_ch_ok
                   && (in_type == TYPE_NOTE_OFF || in_type == TYPE_NOTE_ON)
                   && ({1'b0, in_msg.data_first} < 8'(NOTES));
  assign in_is_cc = in_msg.status_byte[7] && in_ch_ok && (in_type == TYPE_CTRL)
                 && (in_msg.data_first == SUSTAIN_CC);

  assign msg_type = msg.status_byte[7:4];
  assign msg_ch   = msg.status_byte[3:0];
  assign ch_idx   = msg_ch[CW-1:0];
  assign note_on  = (msg_type == TYPE_NOTE_ON) && (msg.data_second != 7'd0);

  assign held       = s1_valid && (ram_rdata == NOTE_HELD);
  assign proc       = s1_valid && (!held || !(buf_valid && buf_full) || res_ready);
  assign scan_issue = (state == ST_SCAN) && (issue_n != (NW+1)'(NOTES))
                   && !(s1_valid && !proc);
  assign scan_end   = (issue_n == (NW+1)'(NOTES)) && !s1_valid;

  assign ram_re    = (accept && in_is_note) || scan_issue;
  assign ram_raddr = (state == ST_SCAN) ? addr_of(ch_idx, issue_n[NW-1:0])
                                        : addr_of(in_ch[CW-1:0], in_msg.data_first[NW-1:0]);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_of(ch_idx, msg.data_first[NW-1:0]);
    ram_wdata = NOTE_OFF;
    res_valid = 1'b0;
    res       = '0;
    note_done = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      ST_NOTE: begin
        if (note_on) begin
          res_valid      = 1'b1;
          res.a_length   = MSG_FULL;
          res.a_data1    = msg.data_first;
          res.last       = 1'b1;
          if (ram_rdata == NOTE_OFF) begin
            res.a_status = {TYPE_NOTE_ON, msg_ch};
            res.a_data2  = msg.data_second;
          end else begin
            res.a_status = {TYPE_NOTE_OFF, msg_ch};
            res.b_status = {TYPE_NOTE_ON, msg_ch};
            res.b_data1  = msg.data_first;
            res.b_data2  = msg.data_second;
          end
          ram_we    = res_ready;
          ram_wdata = NOTE_ON;
          note_done = res_ready;
        end else if (ram_rdata != NOTE_ON) begin
          note_done = 1'b1;
        end else if (flags[ch_idx]) begin
          ram_we    = 1'b1;
          ram_wdata = NOTE_HELD;
          note_done = 1'b1;
        end else begin
          res_valid    = 1'b1;
          res.a_status = {TYPE_NOTE_OFF, msg_ch};
          res.a_data1  = msg.data_first;
          res.a_length = MSG_FULL;
          res.last     = 1'b1;
          ram_we       = res_ready;
          note_done    = res_ready;
        end
      end
      ST_PASS: begin
        res_valid    = 1'b1;
        res.a_status = msg.status_byte;
        res.a_data1  = (msg.msg_length >= 2'd2) ? msg.data_first : 7'd0;
        res.a_data2  = (msg.msg_length == MSG_FULL) ? msg.data_second : 7'd0;
        res.a_length = msg.msg_length;
        res.last     = 1'b1;
      end
      ST_SCAN: begin
        ram_we    = proc && held;
        ram_waddr = addr_of(ch_idx, s1_note);
        res_valid = held && buf_valid && buf_full;
        res.a_status = {TYPE_NOTE_OFF, msg_ch};
        res.a_data1  = 7'(buf_a);
        res.a_length = MSG_FULL;
        res.b_status = {TYPE_NOTE_OFF, msg_ch};
        res.b_data1  = 7'(buf_b);
      end
      ST_FLUSH: begin
        res_valid    = buf_valid;
        res.a_status = {TYPE_NOTE_OFF, msg_ch};
        res.a_data1  = 7'(buf_a);
        res.a_length = MSG_FULL;
        res.last     = 1'b1;
        if (buf_full) begin
          res.b_status = {TYPE_NOTE_OFF, msg_ch};
          res.b_data1  = 7'(buf_b);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      flags     <= '0;
      issue_n   <= '0;
      s1_valid  <= 1'b0;
      buf_valid <= 1'b0;
      buf_full  <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            priority if (!in_msg.status_byte[7]) begin
              state <= ST_IDLE;
            end else if (in_is_note) begin
              state <= ST_NOTE;
            end else if (in_is_cc) begin
              if (in_msg.data_second[6]) begin
                flags[in_ch[CW-1:0]] <= 1'b1;
              end else begin
                flags[in_ch[CW-1:0]] <= 1'b0;
                issue_n   <= '0;
                s1_valid  <= 1'b0;
                buf_valid <= 1'b0;
                buf_full  <= 1'b0;
                state     <= ST_SCAN;
              end
            end else if (in_msg.msg_length != MSG_EMPTY) begin
              state <= ST_PASS;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_NOTE: begin
          if (note_done) begin
            state <= ST_IDLE;
          end
        end
        ST_PASS: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            issue_n  <= issue_n + 1'b1;
            s1_valid <= 1'b1;
          end else if (proc) begin
            s1_valid <= 1'b0;
          end
          if (proc && held) begin
            if (!buf_valid) begin
              buf_valid <= 1'b1;
              buf_full  <= 1'b0;
            end else begin
              buf_full  <= !buf_full;
            end
          end
          if (scan_end) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!buf_valid || res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg <= in_msg;
    end
    if (scan_issue) begin
      s1_note <= issue_n[NW-1:0];
    end
    if (state == ST_SCAN && proc && held) begin
      if (!buf_valid || buf_full) begin
        buf_a <= s1_note;
      end else begin
        buf_b <= s1_note;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (ram_we && ram_wdata == NOTE_OFF))
    else $error("clear pass must write every entry off");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && ram_we) |-> (s1_valid && ram_wdata == NOTE_OFF))
    else $error("release scan wrote without a held note in flight");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && res_valid) |-> !res.last)
    else $error("paired beat during the scan marked final");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !flags[ch_idx])
    else $error("sustain flag still set during release");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && res_valid) |-> (res.last && res.a_status != 8'd0))
    else $error("flush beat must be final and carry a note-off");

endmodule

### rtl/midi_sustain_pedal_emulator.sv
// MIDI sustain pedal emulator: top level.
// Input channel s_* takes one short MIDI message per beat; output channel m_*
// gives result beats carrying up to two messages each, tlast on the final one.
// Note state (off, on, held) per channel and note lives in one RAM of
// CHANNELS*NOTES 2-bit entries; sustain flags are per-channel flip-flops.
// After reset the block walks the RAM clearing one entry a cycle, so s_tready
// stays low until all CHANNELS*NOTES entries (2048 by default) are cleared.
// One message is handled at a time. A note message reads its RAM entry on the
// accepting edge and writes it back from the note state, once the output
// register can take its result beat if it has one; m_tvalid then rises from
// the output register. Pass-through likewise goes through its own state.
// Releasing sustain scans all NOTES entries of the channel through the RAM
// read port, one per cycle unless a waiting pair is held back, and emits
// paired note-offs; s_tready stays low through the scan and the flush of the
// last beat.
// A single output register parts the two sides; when m_tready is low the
// block holds the pending beat and stalls its scan until the register frees.
// s_tdata (low bit up): status_byte[7:0], data_first[14:8],
//   data_second[21:15], msg_length[23:22].
module midi_sustain_pedal_emulator
  import msp_pkg::*;
#(
  parameter int CHANNELS = 16,
  parameter int NOTES = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // status_byte, data_first, data_second, msg_length
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // a_status, a_data1, a_data2, a_length,
                                     // b_status, b_data1, b_data2, 2 pad bits
  output logic             m_tlast
);

  localparam int DEPTH = CHANNELS * NOTES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  msg_t          in_msg;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [1:0]    ram_rdata;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_res;

  assign in_msg.status_byte = s_tdata[7:0];
  assign in_msg.data_first  = s_tdata[14:8];
  assign in_msg.data_second = s_tdata[21:15];
  assign in_msg.msg_length  = s_tdata[23:22];

  msp_ram #(
    .WIDTH(2),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  msp_ctrl #(
    .CHANNELS(CHANNELS),
    .NOTES   (NOTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_msg   (in_msg),
    .in_ready (s_tready),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready)
  );

  msp_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .out_valid(m_tvalid),
    .out_res  (out_res),
    .out_ready(m_tready)
  );

  assign m_tdata = {2'b00, out_res.b_data2, out_res.b_data1, out_res.b_status,
                    out_res.a_length, out_res.a_data2, out_res.a_data1, out_res.a_status};
  assign m_tlast = out_res.last;

endmodule
